@@ hdl/gmcp_pkg.sv @@
`timescale 1ns / 1ps
package gmcp_pkg;

  // fixed field widths
  localparam int COST_W = 16;
  localparam int ACC_W  = 22;
  localparam int POS_W  = 5;
  localparam int CFG_W  = 6;
  localparam int IDX_W  = 1;

  localparam logic [ACC_W-1:0] ACC_MAX = {ACC_W{1'b1}};

  // parameter defaults
  localparam int DEF_MAX_ROWS  = 32;
  localparam int DEF_MAX_COLS  = 32;
  localparam int DEF_COST_BITS = 16;

  // register indexes
  localparam logic [IDX_W-1:0] REG_ROWS = 1'd0;
  localparam logic [IDX_W-1:0] REG_COLS = 1'd1;

  typedef enum logic [1:0] {
    MOVE_NONE,
    MOVE_UP,
    MOVE_LEFT,
    MOVE_DIAG
  } gmcp_move_t;

  // which neighbors of the current cell exist
  typedef struct packed {
    logic has_up;
    logic has_left;
  } gmcp_nbr_t;

endpackage

@@ hdl/gmcp_ram.sv @@
`timescale 1ns / 1ps
module gmcp_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 22,
  parameter int AW    = 10
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hdl/gmcp_step.sv @@
`timescale 1ns / 1ps
module gmcp_step
  import gmcp_pkg::*;
(
  input  gmcp_nbr_t          nbr,
  input  logic [COST_W-1:0]  cost,
  input  logic [ACC_W-1:0]   up,
  input  logic [ACC_W-1:0]   left,
  input  logic [ACC_W-1:0]   diag,
  output gmcp_move_t         move,
  output logic [ACC_W-1:0]   sum
);

  logic [ACC_W-1:0] pred;
  logic [ACC_W:0]   raw;

  // cheapest predecessor; ties prefer up, then left, then diagonal
  always_comb begin
    if (nbr.has_up && nbr.has_left) begin
      if (up <= left && up <= diag) begin
        move = MOVE_UP;
        pred = up;
      end else if (left <= diag) begin
        move = MOVE_LEFT;
        pred = left;
      end else begin
        move = MOVE_DIAG;
        pred = diag;
      end
    end else if (nbr.has_up) begin
      move = MOVE_UP;
      pred = up;
    end else if (nbr.has_left) begin
      move = MOVE_LEFT;
      pred = left;
    end else begin
      move = MOVE_NONE;
      pred = '0;
    end
  end

  assign raw = {1'b0, pred} + (ACC_W + 1)'(cost);
  assign sum = raw[ACC_W] ? ACC_MAX : raw[ACC_W-1:0];

endmodule

@@ hdl/grid_min_cost_path.sv @@
`timescale 1ns / 1ps
// Minimum-cost path through a grid of up to MAX_ROWS x MAX_COLS cells. Write
// grid_rows (index 0) and grid_cols (index 1) first; zero reads as 1 and values
// above the maximum saturate, and any register write restarts loading at the
// top-left cell. Cell costs then arrive as input words in row-major order. A
// word is taken while idle, as the cost table returns the cell above; then the
// shared min/add unit and the table write run, and in_stall holds off the next
// word. The cell to the left and the diagonal cell are held in registers, so
// the table needs a single read port. Costs accumulate and saturate at
// 4194303. Cells before the bottom-right corner produce no output. After the
// corner the block walks back to the top-left: an interior step reads the cell
// above, the left cell and the diagonal in turn through the one port, then
// compares them in the shared unit; top-row and left-column steps read
// nothing. The path is sent start first, one word per cycle when the output
// is not stalled, after a registered path buffer read. Each word carries the
// position, the total cost, and last_cell on the bottom-right corner. in_stall
// stays high from taking the last cell until the final path word is loaded
// into the output register; the next grid can start while that word waits.
module grid_min_cost_path
  import gmcp_pkg::*;
#(
  parameter int MAX_ROWS  = DEF_MAX_ROWS,
  parameter int MAX_COLS  = DEF_MAX_COLS,
  parameter int COST_BITS = DEF_COST_BITS
) (
  input  logic              clk,
  input  logic              rst,
  // configuration
  input  logic              cfg_we,
  input  logic [IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]  cfg_data,
  // cell costs in
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [COST_W-1:0] cell_cost,
  // path cells out
  output logic              out_valid,
  input  logic              out_stall,
  output logic [POS_W-1:0]  path_row,
  output logic [POS_W-1:0]  path_col,
  output logic [ACC_W-1:0]  total_cost,
  output logic              last_cell
);

  localparam int RW         = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CW         = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int TAB_DEPTH  = MAX_ROWS * MAX_COLS;
  localparam int TA         = (TAB_DEPTH > 1) ? $clog2(TAB_DEPTH) : 1;
  localparam int PATH_DEPTH = MAX_ROWS + MAX_COLS - 1;
  localparam int PA         = (PATH_DEPTH > 1) ? $clog2(PATH_DEPTH) : 1;
  localparam int PW         = $clog2(PATH_DEPTH + 1);
  localparam int PE_W       = 2 * POS_W;
  localparam logic [COST_W-1:0] CMASK =
    (COST_BITS >= COST_W) ? {COST_W{1'b1}} : COST_W'((64'd1 << COST_BITS) - 64'd1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CALC,
    S_BT_PUSH,
    S_BT_LF,
    S_BT_DG,
    S_BT_DEC,
    S_EMIT
  } state_t;

  state_t            state;
  logic [RW-1:0]     rlast;
  logic [CW-1:0]     clast;
  logic [RW-1:0]     load_row;
  logic [CW-1:0]     load_col;
  logic [COST_W-1:0] cost_q;
  logic [ACC_W-1:0]  left_sum;
  logic [ACC_W-1:0]  prev_up;
  logic [ACC_W-1:0]  total;
  logic [RW-1:0]     cur_row;
  logic [CW-1:0]     cur_col;
  logic [ACC_W-1:0]  up_q;
  logic [ACC_W-1:0]  lf_q;
  logic [PW-1:0]     path_cnt;
  logic [PW-1:0]     emit_left;
  logic              pend;
  logic              pend_last;

  // cost table and path buffer ports
  logic              tab_we;
  logic [TA-1:0]     tab_waddr;
  logic [TA-1:0]     tab_raddr;
  logic [ACC_W-1:0]  tab_rdata;
  logic              pth_we;
  logic              pth_re;
  logic [PA-1:0]     pth_raddr;
  logic [PE_W-1:0]   pth_rdata;

  // shared min/add unit
  gmcp_nbr_t         nbr;
  logic [ACC_W-1:0]  u_up;
  logic [ACC_W-1:0]  u_left;
  logic [ACC_W-1:0]  u_diag;
  gmcp_move_t        u_move;
  logic [ACC_W-1:0]  u_sum;

  logic              in_take;
  logic              can_load;
  logic              issue;

  function automatic logic [TA-1:0] tab_addr(input logic [RW-1:0] r, input logic [CW-1:0] c);
    return TA'(int'(r) * MAX_COLS + int'(c));
  endfunction

  function automatic logic [RW-1:0] rows_last(input logic [CFG_W-1:0] v);
    if (v == '0) return '0;
    if (int'(v) > MAX_ROWS) return RW'(MAX_ROWS - 1);
    return RW'(v - CFG_W'(1));
  endfunction

  function automatic logic [CW-1:0] cols_last(input logic [CFG_W-1:0] v);
    if (v == '0) return '0;
    if (int'(v) > MAX_COLS) return CW'(MAX_COLS - 1);
    return CW'(v - CFG_W'(1));
  endfunction

  assign in_stall = (state != S_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign can_load = !out_valid || !out_stall;
  // path buffer read: one per free output slot
  assign issue    = (state == S_EMIT) && (emit_left != '0) && (!pend || can_load);

  // table read address: cell above while idle, then the three neighbors
  always_comb begin
    case (state)
      S_BT_PUSH: tab_raddr = tab_addr(cur_row - RW'(1), cur_col);
      S_BT_LF:   tab_raddr = tab_addr(cur_row, cur_col - CW'(1));
      S_BT_DG:   tab_raddr = tab_addr(cur_row - RW'(1), cur_col - CW'(1));
      default:   tab_raddr = tab_addr(load_row - RW'(load_row != '0), load_col);
    endcase
  end

  assign tab_we    = (state == S_CALC);
  assign tab_waddr = tab_addr(load_row, load_col);
  assign pth_we    = (state == S_BT_PUSH);
  assign pth_re    = issue;
  assign pth_raddr = PA'(emit_left - PW'(1));

  // unit inputs: loading uses the fresh read plus held neighbors,
  // backtracking uses the three reads gathered in turn
  always_comb begin
    if (state == S_BT_DEC) begin
      nbr    = '{has_up: 1'b1, has_left: 1'b1};
      u_up   = up_q;
      u_left = lf_q;
      u_diag = tab_rdata;
    end else begin
      nbr    = '{has_up: (load_row != '0), has_left: (load_col != '0)};
      u_up   = tab_rdata;
      u_left = left_sum;
      u_diag = prev_up;
    end
  end

  gmcp_step u_step (
    .nbr  (nbr),
    .cost (cost_q),
    .up   (u_up),
    .left (u_left),
    .diag (u_diag),
    .move (u_move),
    .sum  (u_sum)
  );

  gmcp_ram #(
    .DEPTH (TAB_DEPTH),
    .WIDTH (ACC_W),
    .AW    (TA)
  ) u_cost_tab (
    .clk   (clk),
    .we    (tab_we),
    .waddr (tab_waddr),
    .wdata (u_sum),
    .re    (1'b1),
    .raddr (tab_raddr),
    .rdata (tab_rdata)
  );

  gmcp_ram #(
    .DEPTH (PATH_DEPTH),
    .WIDTH (PE_W),
    .AW    (PA)
  ) u_path_buf (
    .clk   (clk),
    .we    (pth_we),
    .waddr (path_cnt[PA-1:0]),
    .wdata ({POS_W'(cur_row), POS_W'(cur_col)}),
    .re    (pth_re),
    .raddr (pth_raddr),
    .rdata (pth_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rlast     <= '0;
      clast     <= '0;
      load_row  <= '0;
      load_col  <= '0;
      path_cnt  <= '0;
      emit_left <= '0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_take) begin
            cost_q <= cell_cost & CMASK;
            state  <= S_CALC;
          end
        end

        S_CALC: begin
          left_sum <= u_sum;
          prev_up  <= tab_rdata;
          state    <= S_IDLE;
          if (load_col != clast) begin
            load_col <= load_col + CW'(1);
          end else if (load_row != rlast) begin
            load_row <= load_row + RW'(1);
            load_col <= '0;
          end else begin
            // corner reached: start the walk back
            load_row <= '0;
            load_col <= '0;
            total    <= u_sum;
            cur_row  <= load_row;
            cur_col  <= load_col;
            path_cnt <= '0;
            state    <= S_BT_PUSH;
          end
        end

        S_BT_PUSH: begin
          path_cnt <= path_cnt + PW'(1);
          if (cur_row == '0 && cur_col == '0) begin
            emit_left <= path_cnt + PW'(1);
            pend      <= 1'b0;
            state     <= S_EMIT;
          end else if (cur_row == '0) begin
            cur_col <= cur_col - CW'(1);
          end else if (cur_col == '0) begin
            cur_row <= cur_row - RW'(1);
          end else begin
            state <= S_BT_LF;
          end
        end

        S_BT_LF: begin
          up_q  <= tab_rdata;
          state <= S_BT_DG;
        end

        S_BT_DG: begin
          lf_q  <= tab_rdata;
          state <= S_BT_DEC;
        end

        S_BT_DEC: begin
          case (u_move)
            MOVE_UP: cur_row <= cur_row - RW'(1);
            MOVE_LEFT: cur_col <= cur_col - CW'(1);
            MOVE_DIAG: begin
              cur_row <= cur_row - RW'(1);
              cur_col <= cur_col - CW'(1);
            end
            default: ;
          endcase
          state <= S_BT_PUSH;
        end

        S_EMIT: begin
          if (pend && can_load) begin
            path_row   <= pth_rdata[PE_W-1:POS_W];
            path_col   <= pth_rdata[POS_W-1:0];
            total_cost <= total;
            last_cell  <= pend_last;
            out_valid  <= 1'b1;
            pend       <= 1'b0;
          end
          if (issue) begin
            pend      <= 1'b1;
            pend_last <= (emit_left == PW'(1));
            emit_left <= emit_left - PW'(1);
          end else if (emit_left == '0 && (!pend || can_load)) begin
            state <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase

      // register writes must arrive only while idle (unchecked by the block)
      if (cfg_we) begin
        case (cfg_index)
          REG_ROWS: begin
            rlast    <= rows_last(cfg_data);
            load_row <= '0;
            load_col <= '0;
          end
          REG_COLS: begin
            clast    <= cols_last(cfg_data);
            load_row <= '0;
            load_col <= '0;
          end
          default: ;
        endcase
      end
    end
  end

`ifndef ASSERT_OFF
  a_out_from_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_EMIT)
    else $error("output word loaded outside the emit phase");

  a_load_in_grid: assert property (@(posedge clk) disable iff (rst)
    load_row <= rlast && load_col <= clast)
    else $error("load position outside the grid");

  a_walk_in_grid: assert property (@(posedge clk) disable iff (rst)
    state == S_BT_PUSH |-> cur_row <= rlast && cur_col <= clast)
    else $error("backtrack left the grid");

  a_path_fits: assert property (@(posedge clk) disable iff (rst)
    state == S_BT_PUSH |-> int'(path_cnt) < PATH_DEPTH)
    else $error("path longer than the path buffer");

  a_emit_done: assert property (@(posedge clk) disable iff (rst)
    state == S_EMIT && emit_left == '0 && !pend |=> state == S_IDLE)
    else $error("emit phase did not end after the last word");
`endif

endmodule

@@ tb/sv/grid_min_cost_path_checker.sv @@
`timescale 1ns / 1ps
// Watches the config port and both word channels. It keeps its own copy of the
// accumulated-cost table, predicts the path words for every completed grid, and
// compares them in order against the output channel.
module grid_min_cost_path_checker
  import gmcp_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]  cfg_data,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic [COST_W-1:0] cell_cost,
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic [POS_W-1:0]  path_row,
  input  logic [POS_W-1:0]  path_col,
  input  logic [ACC_W-1:0]  total_cost,
  input  logic              last_cell,
  input  logic              end_check,
  output int                pending,
  output int                fail_count,
  output int                words_checked
);

  localparam int TBL_DEPTH = DEF_MAX_ROWS * DEF_MAX_COLS;
  localparam logic [COST_W-1:0] COST_MASK = COST_W'((1 << DEF_COST_BITS) - 1);

  typedef struct packed {
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
    logic [ACC_W-1:0] total;
    logic             last;
  } path_word_t;

  logic [ACC_W-1:0] acc_tbl [TBL_DEPTH];
  logic [CFG_W-1:0] rows_reg;
  logic [CFG_W-1:0] cols_reg;
  int unsigned      next_row;
  int unsigned      next_col;
  path_word_t       path_q[$];
  bit               leftovers_counted;

  // zero reads as one, oversize saturates
  function automatic int unsigned used_dim(logic [CFG_W-1:0] v, int unsigned lim);
    if (v == '0) return 1;
    return (32'(v) > lim) ? lim : 32'(v);
  endfunction

  function automatic logic [ACC_W-1:0] acc_at(int unsigned r, int unsigned c);
    return acc_tbl[r * DEF_MAX_COLS + c];
  endfunction

  // one cost word: update the table, and on the corner cell walk back
  task automatic take_cell(input logic [COST_W-1:0] cost);
    int unsigned      rows;
    int unsigned      cols;
    int unsigned      r;
    int unsigned      c;
    int unsigned      pred;
    int unsigned      total;
    logic [ACC_W-1:0] up_acc;
    logic [ACC_W-1:0] lf_acc;
    logic [ACC_W-1:0] dg_acc;
    gmcp_move_t       step;
    path_word_t       trail[$];
    path_word_t       w;
    rows = used_dim(rows_reg, DEF_MAX_ROWS);
    cols = used_dim(cols_reg, DEF_MAX_COLS);
    r = (next_row >= rows) ? rows - 1 : next_row;
    c = (next_col >= cols) ? cols - 1 : next_col;
    if (r == 0 && c == 0) pred = 0;
    else if (r == 0) pred = 32'(acc_at(0, c - 1));
    else if (c == 0) pred = 32'(acc_at(r - 1, 0));
    else begin
      pred = 32'(acc_at(r - 1, c - 1));
      if (32'(acc_at(r - 1, c)) < pred) pred = 32'(acc_at(r - 1, c));
      if (32'(acc_at(r, c - 1)) < pred) pred = 32'(acc_at(r, c - 1));
    end
    total = pred + 32'(cost & COST_MASK);
    if (total > 32'(ACC_MAX)) total = 32'(ACC_MAX);
    acc_tbl[r * DEF_MAX_COLS + c] = ACC_W'(total);
    if (c + 1 < cols) begin
      next_row = r;
      next_col = c + 1;
      return;
    end
    if (r + 1 < rows) begin
      next_row = r + 1;
      next_col = 0;
      return;
    end
    next_row = 0;
    next_col = 0;
    // corner goes in first, so it is the one flagged last
    forever begin
      w.row   = POS_W'(r);
      w.col   = POS_W'(c);
      w.total = ACC_W'(total);
      w.last  = (trail.size() == 0);
      trail.push_front(w);
      if (r == 0 && c == 0) break;
      if (r == 0) step = MOVE_LEFT;
      else if (c == 0) step = MOVE_UP;
      else begin
        up_acc = acc_at(r - 1, c);
        lf_acc = acc_at(r, c - 1);
        dg_acc = acc_at(r - 1, c - 1);
        // ties: up, then left, then diagonal
        if (up_acc <= lf_acc && up_acc <= dg_acc) step = MOVE_UP;
        else if (lf_acc <= dg_acc) step = MOVE_LEFT;
        else step = MOVE_DIAG;
      end
      if (step != MOVE_LEFT) r--;
      if (step != MOVE_UP) c--;
    end
    foreach (trail[i]) path_q.push_back(trail[i]);
  endtask

  task automatic check_word();
    path_word_t want;
    path_word_t got;
    got = {path_row, path_col, total_cost, last_cell};
    words_checked++;
    if (path_q.size() == 0) begin
      fail_count++;
      if (fail_count <= 10)
        $display("%0t: unexpected path word row %0d col %0d cost %0d last %0b",
                 $time, got.row, got.col, got.total, got.last);
      return;
    end
    want = path_q.pop_front();
    if (got !== want) begin
      fail_count++;
      if (fail_count <= 10)
        $display("%0t: want %0d,%0d cost %0d last %0b, got %0d,%0d cost %0d last %0b",
                 $time, want.row, want.col, want.total, want.last,
                 got.row, got.col, got.total, got.last);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      rows_reg = CFG_W'(1);
      cols_reg = CFG_W'(1);
      next_row = 0;
      next_col = 0;
      path_q.delete();
    end else begin
      if (out_valid && !out_stall) check_word();
      if (cfg_we) begin
        if (cfg_index == REG_ROWS) begin
          rows_reg = cfg_data;
          next_row = 0;
          next_col = 0;
        end else if (cfg_index == REG_COLS) begin
          cols_reg = cfg_data;
          next_row = 0;
          next_col = 0;
        end
      end
      if (in_valid && !in_stall) take_cell(cell_cost);
      if (end_check && !leftovers_counted) begin
        leftovers_counted = 1;
        if (path_q.size() != 0) begin
          fail_count += path_q.size();
          $display("%0d path words never arrived", path_q.size());
        end
      end
    end
    pending <= path_q.size();
  end

endmodule

@@ tb/sv/grid_min_cost_path_tb.sv @@
`timescale 1ns / 1ps
// Top of the bench: clock, reset, stimulus and verdict. All prediction and
// comparison lives in the checker instantiated next to the block.
module grid_min_cost_path_tb;
  import gmcp_pkg::*;

  // random part length, counted in cost words
  localparam int RANDOM_WORDS  = 120;
  // slack after the last expected word before touching the registers;
  // covers a partly loaded grid still in its table pass
  localparam int SETTLE_CYCLES = 16;
  // long output hold-off, long enough to back the block up into its input
  localparam int HOLD_CYCLES   = 400;
  localparam int DRAIN_CYCLES  = 64;
  // watchdog limit, above the slowest legal run
  localparam int CYCLE_LIMIT   = 500000;

  // flavors of random cell costs
  typedef enum int {
    COSTS_TIES,  // 0..3, lots of equal neighbors
    COSTS_LOW,   // 0..15
    COSTS_FULL,  // whole 16-bit range
    COSTS_HIGH   // near all-ones
  } cost_mix_t;

  logic              clk       = 1'b0;
  logic              rst       = 1'b1;
  logic              cfg_we    = 1'b0;
  logic [IDX_W-1:0]  cfg_index = REG_ROWS;
  logic [CFG_W-1:0]  cfg_data  = '0;
  logic              in_valid  = 1'b0;
  logic              in_stall;
  logic [COST_W-1:0] cell_cost = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [POS_W-1:0]  path_row;
  logic [POS_W-1:0]  path_col;
  logic [ACC_W-1:0]  total_cost;
  logic              last_cell;

  logic              end_check = 1'b0;
  int                pending;
  int                fail_count;
  int                words_checked;

  // idle / stall odds in percent, changed per phase
  int                idle_pct  = 0;
  int                stall_pct = 0;
  logic              hold_req  = 1'b0;
  logic              long_hold = 1'b0;

  int                cycles;
  int                words_sent;
  int                grids_done;
  int                grids_dropped;
  // grid shape as the block sees it after clamping
  int unsigned       cur_rows = 1;
  int unsigned       cur_cols = 1;
  // set after a partial load: the next grid must start with a register write
  bit                reload_needed;

  grid_min_cost_path u_top (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .cell_cost  (cell_cost),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .path_row   (path_row),
    .path_col   (path_col),
    .total_cost (total_cost),
    .last_cell  (last_cell)
  );

  grid_min_cost_path_checker u_check (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .cell_cost     (cell_cost),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .path_row      (path_row),
    .path_col      (path_col),
    .total_cost    (total_cost),
    .last_cell     (last_cell),
    .end_check     (end_check),
    .pending       (pending),
    .fail_count    (fail_count),
    .words_checked (words_checked)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d path words owed", cycles, pending);
      $display("FAIL");
      $finish;
    end
  end

  // receiver: random stalls, or solid stall during the long hold-off
  always @(posedge clk) begin
    if (long_hold) out_stall <= 1'b1;
    else out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  // one long hold-off, counted here, started on request from the stimulus
  initial begin
    while (!hold_req) @(posedge clk);
    long_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    long_hold <= 1'b0;
  end

  function automatic int unsigned grid_dim(logic [CFG_W-1:0] v, int unsigned lim);
    if (v == '0) return 1;
    return (32'(v) > lim) ? lim : 32'(v);
  endfunction

  // mostly small sizes; now and then zero or something at/above the maximum
  function automatic logic [CFG_W-1:0] pick_dim();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 4) return '0;
    if (roll < 7) return CFG_W'($urandom_range(DEF_MAX_ROWS, 63));
    return CFG_W'($urandom_range(1, 5));
  endfunction

  function automatic logic [COST_W-1:0] rand_cost(cost_mix_t mix);
    case (mix)
      COSTS_TIES: return COST_W'($urandom_range(0, 3));
      COSTS_LOW:  return COST_W'($urandom_range(0, 15));
      COSTS_FULL: return COST_W'($urandom);
      default:    return 16'hFFFF - COST_W'($urandom_range(0, 3));
    endcase
  endfunction

  // offer one cost word, with random idle cycles ahead of it; returns at the
  // edge where the word was taken
  task automatic send_cell(input logic [COST_W-1:0] cost);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    cell_cost <= cost;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    words_sent++;
  endtask

  // stop sending and wait for every owed path word, then some slack
  task automatic settle();
    in_valid <= 1'b0;
    // pending is registered, so wait for it to catch up
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // write both size registers back to back on a quiet block
  task automatic set_size(input logic [CFG_W-1:0] rv, input logic [CFG_W-1:0] cv);
    settle();
    cfg_we    <= 1'b1;
    cfg_index <= REG_ROWS;
    cfg_data  <= rv;
    @(posedge clk);
    cfg_index <= REG_COLS;
    cfg_data  <= cv;
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_rows = grid_dim(rv, DEF_MAX_ROWS);
    cur_cols = grid_dim(cv, DEF_MAX_COLS);
    reload_needed = 0;
  endtask

  // 2x2 grid, row-major
  task automatic square(input logic [COST_W-1:0] a, input logic [COST_W-1:0] b,
                        input logic [COST_W-1:0] c, input logic [COST_W-1:0] d);
    send_cell(a);
    send_cell(b);
    send_cell(c);
    send_cell(d);
    grids_done++;
  endtask

  // one random grid: maybe a new size, a cost flavor, and now and then a
  // grid cut short so the next register write has to drop it
  task automatic run_grid(input bit fixed, input logic [CFG_W-1:0] fr,
                          input logic [CFG_W-1:0] fc);
    logic [CFG_W-1:0] rv;
    logic [CFG_W-1:0] cv;
    cost_mix_t        mix;
    int unsigned      n_cells;
    int unsigned      cut;
    if (fixed) begin
      rv = fr;
      cv = fc;
    end else begin
      rv = pick_dim();
      cv = pick_dim();
      // keep big shapes to one long side only
      if (grid_dim(rv, DEF_MAX_ROWS) * grid_dim(cv, DEF_MAX_COLS) > 64)
        cv = CFG_W'($urandom_range(1, 2));
    end
    if (fixed || reload_needed || $urandom_range(0, 99) < 60) set_size(rv, cv);
    mix     = cost_mix_t'($urandom_range(0, 3));
    n_cells = cur_rows * cur_cols;
    cut     = n_cells;
    if (n_cells > 1 && $urandom_range(0, 99) < 10) cut = $urandom_range(1, n_cells - 1);
    for (int i = 0; i < cut; i++) send_cell(rand_cost(mix));
    if (cut < n_cells) begin
      grids_dropped++;
      reload_needed = 1;
    end else begin
      grids_done++;
    end
  endtask

  initial begin
    int start;
    int g;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // --- directed ---
    // 1x1 out of reset: every word is a whole grid; cost extremes
    send_cell(16'h0000);
    grids_done++;
    send_cell(16'hFFFF);
    grids_done++;
    // zero sizes read as 1x1
    set_size('0, '0);
    send_cell(16'h5A5A);
    grids_done++;
    // 2x2 backtrack choices at the corner
    set_size(6'd2, 6'd2);
    square(0, 0, 0, 0);  // three-way tie, goes up
    square(3, 0, 5, 1);  // up ties diagonal, up wins
    square(3, 4, 0, 2);  // left ties diagonal, left wins
    square(3, 4, 1, 7);  // diagonal strictly cheapest
    // half a grid, then a register write throws it away
    send_cell(16'd7);
    send_cell(16'd9);
    grids_dropped++;
    reload_needed = 1;

    start = words_sent;

    // --- backpressure: hold the output while grids keep coming ---
    set_size(6'd3, 6'd3);
    hold_req <= 1'b1;
    repeat (3) begin
      for (int i = 0; i < 9; i++) send_cell(rand_cost(COSTS_LOW));
      grids_done++;
    end

    // --- random grids, four idle/stall phases ---
    g = 0;
    while (words_sent - start < RANDOM_WORDS) begin
      case ((words_sent - start) * 4 / RANDOM_WORDS)
        0: begin
          idle_pct  = 0;
          stall_pct = 0;
        end
        1: begin
          idle_pct  = 78;
          stall_pct = 0;
        end
        2: begin
          idle_pct  = 0;
          stall_pct = 78;
        end
        default: begin
          idle_pct  = 26;
          stall_pct = 26;
        end
      endcase
      // one tall and one wide grid through saturated size registers
      if (g == 3) run_grid(1'b1, 6'd63, 6'd1);
      else if (g == 10) run_grid(1'b1, 6'd1, 6'd63);
      else run_grid(1'b0, '0, '0);
      g++;
    end

    // --- drain and verdict ---
    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    end_check <= 1'b1;
    repeat (2) @(posedge clk);
    $display("Covered %0d cost words: %0d full grids, %0d dropped loads, %0d path words checked",
             words_sent, grids_done, grids_dropped, words_checked);
    $display("Shapes from 1x1 to 32 on a side, tie-heavy costs, clamped sizes, long output hold");
    if (fail_count == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
